// File: design/cdad_pkg.sv
// ----------------------------------------------------------------------------
// cdad_pkg
// Shared types, constants and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
package cdad_pkg;

  localparam int DayW       = 5;
  localparam int MonthW     = 4;
  localparam int YearW      = 14;
  localparam int DeltaW     = 16;
  localparam int AccW       = 17;
  localparam int YearAccW   = 16;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 24;

  localparam logic [MonthW-1:0] MonthFirst = 4'd1;
  localparam logic [MonthW-1:0] MonthLast  = 4'd12;
  localparam logic [YearW-1:0]  Cycle400   = 14'd400;
  localparam logic [YearW-1:0]  Cycle400M1 = 14'd399;
  localparam logic [YearW-1:0]  Cent1      = 14'd100;
  localparam logic [YearW-1:0]  Cent2      = 14'd200;
  localparam logic [YearW-1:0]  Cent3      = 14'd300;
  localparam logic [YearW-1:0]  YearMax    = 14'd9999;
  localparam logic [DayW-1:0]   DayMax     = 5'd31;

  localparam logic [MonthW-1:0] MonApr = 4'd4;
  localparam logic [MonthW-1:0] MonJun = 4'd6;
  localparam logic [MonthW-1:0] MonSep = 4'd9;
  localparam logic [MonthW-1:0] MonNov = 4'd11;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_NORM,
    ST_DONE
  } state_t;

  // The argument is the year reduced modulo 400.
  function automatic logic is_leap(input logic [YearW-1:0] ymod);
    logic century;
    century = (ymod == Cent1) || (ymod == Cent2) || (ymod == Cent3);
    return (ymod == '0) || (!century && (ymod[1:0] == 2'b00));
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] r;
    unique case (m)
      MonApr, MonJun, MonSep, MonNov: r = 5'd30;
      MonFeb:                         r = leap ? 5'd29 : 5'd28;
      default:                        r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// File: design/calendar_date_add_days_top.sv
// ----------------------------------------------------------------------------
// calendar_date_add_days_top
// Adds a signed day count to a Gregorian date, one month per cycle.
// ----------------------------------------------------------------------------
// An item goes from its transfer through a year reduction and a walk across M
// months, where M is the number of months the sum of day and delta walks
// across: the year is first reduced modulo 400 for the leap test, and one
// shared add/compare unit then steps the day count one month per cycle,
// about 1077 months for the largest delta. The result sits in an output
// register; a new item is taken as soon as the sequencer is idle, even while
// an earlier result waits. A result year outside 1..9999 saturates the date
// and sets the flag in m_tuser.
module calendar_date_add_days_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // in_day, in_month, in_year, day_delta, zero pad (from bit 0 up)
  input  logic [cdad_pkg::InDataW-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_day, out_month, out_year, zero pad (from bit 0 up)
  output logic [cdad_pkg::OutDataW-1:0] m_tdata,
  // range_error
  output logic                          m_tuser
);

  cdad_pkg::state_t                    state, state_next;
  logic signed [cdad_pkg::AccW-1:0]    day_acc, day_acc_next;
  logic [cdad_pkg::MonthW-1:0]         month, month_next;
  logic signed [cdad_pkg::YearAccW-1:0] year, year_next;
  logic [cdad_pkg::YearW-1:0]          ymod, ymod_next;

  logic [cdad_pkg::DayW-1:0]   in_day;
  logic [cdad_pkg::MonthW-1:0] in_month;
  logic [cdad_pkg::YearW-1:0]  in_year;
  logic [cdad_pkg::DeltaW-1:0] day_delta;

  logic [cdad_pkg::MonthW-1:0] month_prev;
  logic [cdad_pkg::YearW-1:0]  ymod_prev;
  logic [cdad_pkg::DayW-1:0]   md_cur, md_prev;
  logic                        day_low, day_high;
  logic signed [cdad_pkg::AccW-1:0] addend, sum;
  logic                        load_out;
  logic                        err_low, err_high;
  logic [cdad_pkg::DayW-1:0]   res_day;
  logic [cdad_pkg::MonthW-1:0] res_month;
  logic [cdad_pkg::YearW-1:0]  res_year;

  assign in_day    = s_tdata[4:0];
  assign in_month  = s_tdata[8:5];
  assign in_year   = s_tdata[22:9];
  assign day_delta = s_tdata[38:23];

  assign s_tready = (state == cdad_pkg::ST_IDLE);

  // Shared month step: borrow the previous month or consume the current one.
  assign month_prev = (month == cdad_pkg::MonthFirst) ? cdad_pkg::MonthLast
                                                      : month - 4'd1;
  assign ymod_prev  = (month != cdad_pkg::MonthFirst) ? ymod :
                      (ymod == '0) ? cdad_pkg::Cycle400M1 : ymod - 14'd1;
  assign md_cur   = cdad_pkg::month_days(month, cdad_pkg::is_leap(ymod));
  assign md_prev  = cdad_pkg::month_days(month_prev, cdad_pkg::is_leap(ymod_prev));
  assign day_low  = (day_acc < 17'sd1);
  assign day_high = (day_acc > $signed({12'b0, md_cur}));
  assign addend   = day_low ? $signed({12'b0, md_prev}) : -$signed({12'b0, md_cur});
  assign sum      = day_acc + addend;

  assign err_low  = (year < 16'sd1);
  assign err_high = (year > $signed({2'b0, cdad_pkg::YearMax}));

  always_comb begin
    res_day   = day_acc[cdad_pkg::DayW-1:0];
    res_month = month;
    res_year  = year[cdad_pkg::YearW-1:0];
    if (err_low) begin
      res_day   = 5'd1;
      res_month = cdad_pkg::MonthFirst;
      res_year  = 14'd1;
    end else if (err_high) begin
      res_day   = cdad_pkg::DayMax;
      res_month = cdad_pkg::MonthLast;
      res_year  = cdad_pkg::YearMax;
    end
  end

  always_comb begin
    state_next   = state;
    day_acc_next = day_acc;
    month_next   = month;
    year_next    = year;
    ymod_next    = ymod;
    load_out     = 1'b0;
    unique case (state)
      cdad_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          day_acc_next = $signed({day_delta[cdad_pkg::DeltaW-1], day_delta})
                         + $signed({12'b0, in_day});
          if (in_month < cdad_pkg::MonthFirst) begin
            month_next = cdad_pkg::MonthFirst;
          end else if (in_month > cdad_pkg::MonthLast) begin
            month_next = cdad_pkg::MonthLast;
          end else begin
            month_next = in_month;
          end
          year_next  = $signed({2'b0, in_year});
          ymod_next  = in_year;
          state_next = cdad_pkg::ST_MOD;
        end
      end
      cdad_pkg::ST_MOD: begin
        if (ymod >= cdad_pkg::Cycle400) begin
          ymod_next = ymod - cdad_pkg::Cycle400;
        end else begin
          state_next = cdad_pkg::ST_NORM;
        end
      end
      cdad_pkg::ST_NORM: begin
        if (day_low) begin
          day_acc_next = sum;
          month_next   = month_prev;
          ymod_next    = ymod_prev;
          if (month == cdad_pkg::MonthFirst) begin
            year_next = year - 16'sd1;
          end
        end else if (day_high) begin
          day_acc_next = sum;
          if (month == cdad_pkg::MonthLast) begin
            month_next = cdad_pkg::MonthFirst;
            year_next  = year + 16'sd1;
            ymod_next  = (ymod == cdad_pkg::Cycle400M1) ? '0 : ymod + 14'd1;
          end else begin
            month_next = month + 4'd1;
          end
        end else begin
          state_next = cdad_pkg::ST_DONE;
        end
      end
      cdad_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = cdad_pkg::ST_IDLE;
        end
      end
      default: state_next = cdad_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cdad_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    day_acc <= day_acc_next;
    month   <= month_next;
    year    <= year_next;
    ymod    <= ymod_next;
    if (load_out) begin
      m_tdata <= {1'b0, res_year, res_month, res_day};
      m_tuser <= err_low || err_high;
    end
  end

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (state == cdad_pkg::ST_NORM) |-> (month >= cdad_pkg::MonthFirst) &&
                                     (month <= cdad_pkg::MonthLast))
    else $error("month left 1..12 during normalization");

  a_ymod_range: assert property (@(posedge clk) disable iff (rst)
    (state == cdad_pkg::ST_NORM) |-> (ymod < cdad_pkg::Cycle400))
    else $error("year residue not reduced below 400");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == cdad_pkg::ST_MOD))
    else $error("accepted transfer did not start the sequencer");

  a_done_in_month: assert property (@(posedge clk) disable iff (rst)
    (state == cdad_pkg::ST_DONE) |-> (day_acc >= 17'sd1) &&
                                     (day_acc <= $signed({12'b0, md_cur})))
    else $error("day not normalized into its month");

  a_sat_year: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[22:9] == 14'd1) ||
                              (m_tdata[22:9] == cdad_pkg::YearMax))
    else $error("saturated result with a year other than 1 or 9999");

endmodule

// File: tb/calendar_date_add_days_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_add_days_top_tb
// Checks the date adder against a behavioral calendar walk in the bench.
// Each date and signed day count sent is worked out month by month here.
// The result is queued and compared field by field with the block's output.
// The run covers directed leap year, boundary and saturation dates first.
// Random dates follow with idle bursts on both streams, and the last part of
// the run has no idling at all.
// ----------------------------------------------------------------------------
module calendar_date_add_days_top_tb;

  typedef struct {
    logic [cdad_pkg::DayW-1:0]   day;
    logic [cdad_pkg::MonthW-1:0] month;
    logic [cdad_pkg::YearW-1:0]  year;
    logic                        range_error;
  } date_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [cdad_pkg::InDataW-1:0]  s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [cdad_pkg::OutDataW-1:0] m_tdata;
  logic                          m_tuser;

  date_t pending_dates[$];
  bit    bursts_on = 1'b1;
  int    dates_sent = 0;
  int    results_checked = 0;
  int    saturated_seen = 0;
  int    mismatches = 0;

  calendar_date_add_days_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic bit gregorian_leap(input int y);
    if ((y % 400) == 0) return 1'b1;
    if ((y % 100) == 0) return 1'b0;
    return (y % 4) == 0;
  endfunction

  function automatic int month_length(input int m, input int y);
    if (m == cdad_pkg::MonApr || m == cdad_pkg::MonJun ||
        m == cdad_pkg::MonSep || m == cdad_pkg::MonNov) return 30;
    if (m == cdad_pkg::MonFeb) return gregorian_leap(y) ? 29 : 28;
    return 31;
  endfunction

  function automatic date_t date_after_days(input logic [cdad_pkg::DayW-1:0] day,
                                            input logic [cdad_pkg::MonthW-1:0] month,
                                            input logic [cdad_pkg::YearW-1:0] year,
                                            input logic signed [cdad_pkg::DeltaW-1:0] delta);
    int    d;
    int    m;
    int    y;
    date_t r;
    d = int'(day);
    m = int'(month);
    y = int'(year);
    if (m < cdad_pkg::MonthFirst) m = int'(cdad_pkg::MonthFirst);
    if (m > cdad_pkg::MonthLast) m = int'(cdad_pkg::MonthLast);
    d = d + int'(delta);
    while (d < 1) begin
      m--;
      if (m == 0) begin
        m = int'(cdad_pkg::MonthLast);
        y--;
      end
      d += month_length(m, y);
    end
    while (d > month_length(m, y)) begin
      d -= month_length(m, y);
      m++;
      if (m == cdad_pkg::MonthLast + 1) begin
        m = int'(cdad_pkg::MonthFirst);
        y++;
      end
    end
    r.range_error = 1'b0;
    if (y < 1) begin
      d = 1;
      m = int'(cdad_pkg::MonthFirst);
      y = 1;
      r.range_error = 1'b1;
    end else if (y > cdad_pkg::YearMax) begin
      d = int'(cdad_pkg::DayMax);
      m = int'(cdad_pkg::MonthLast);
      y = int'(cdad_pkg::YearMax);
      r.range_error = 1'b1;
    end
    r.day = d[cdad_pkg::DayW-1:0];
    r.month = m[cdad_pkg::MonthW-1:0];
    r.year = y[cdad_pkg::YearW-1:0];
    return r;
  endfunction

  task automatic send_date(input int day, input int month, input int year,
                           input int delta);
    int                                 gap;
    bit                                 ready_seen;
    logic [cdad_pkg::DayW-1:0]          day_f;
    logic [cdad_pkg::MonthW-1:0]        month_f;
    logic [cdad_pkg::YearW-1:0]         year_f;
    logic signed [cdad_pkg::DeltaW-1:0] delta_f;
    day_f = day[cdad_pkg::DayW-1:0];
    month_f = month[cdad_pkg::MonthW-1:0];
    year_f = year[cdad_pkg::YearW-1:0];
    delta_f = delta[cdad_pkg::DeltaW-1:0];
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {1'b0, delta_f, year_f, month_f, day_f};
    s_tvalid <= 1'b1;
    ready_seen = 1'b0;
    while (!ready_seen) begin
      @(negedge clk);
      ready_seen = (s_tready === 1'b1);
      @(posedge clk);
    end
    pending_dates.push_back(date_after_days(day_f, month_f, year_f, delta_f));
    dates_sent++;
  endtask

  task automatic check_result(input logic [cdad_pkg::OutDataW-1:0] data, input logic flag);
    date_t want;
    if (pending_dates.size() == 0) begin
      $error("result transfer with no date pending: tdata=%h tuser=%b", data, flag);
      mismatches++;
      return;
    end
    want = pending_dates.pop_front();
    results_checked++;
    if (flag === 1'b1) saturated_seen++;
    if (data[cdad_pkg::DayW-1:0] !== want.day) begin
      $error("out_day: expected %0d, got %0d", want.day, data[cdad_pkg::DayW-1:0]);
      mismatches++;
    end
    if (data[cdad_pkg::DayW+cdad_pkg::MonthW-1:cdad_pkg::DayW] !== want.month) begin
      $error("out_month: expected %0d, got %0d", want.month,
             data[cdad_pkg::DayW+cdad_pkg::MonthW-1:cdad_pkg::DayW]);
      mismatches++;
    end
    if (data[cdad_pkg::DayW+cdad_pkg::MonthW+cdad_pkg::YearW-1:
             cdad_pkg::DayW+cdad_pkg::MonthW] !== want.year) begin
      $error("out_year: expected %0d, got %0d", want.year,
             data[cdad_pkg::DayW+cdad_pkg::MonthW+cdad_pkg::YearW-1:
                  cdad_pkg::DayW+cdad_pkg::MonthW]);
      mismatches++;
    end
    if (flag !== want.range_error) begin
      $error("range_error: expected %0b, got %0b", want.range_error, flag);
      mismatches++;
    end
  endtask

  initial begin
    bit                            took;
    logic [cdad_pkg::OutDataW-1:0] data;
    logic                          flag;
    int                            stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      took = (m_tvalid === 1'b1) && (m_tready === 1'b1);
      data = m_tdata;
      flag = m_tuser;
      @(posedge clk);
      if (took) check_result(data, flag);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (bursts_on && stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        m_tready <= 1'b0;
      end else begin
        stall_left = 0;
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_random_date();
    int day;
    int month;
    int year;
    int delta;
    int pick;
    day = $urandom_range(0, 31);
    month = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    pick = $urandom_range(0, 19);
    if (pick == 0) year = 0;
    else if (pick == 1) year = $urandom_range(10000, 16383);
    else if (pick == 2) year = $urandom_range(1, 3);
    else if (pick == 3) year = $urandom_range(9997, 9999);
    else year = $urandom_range(1, 9999);
    pick = $urandom_range(0, 19);
    if (pick < 12) delta = $urandom_range(0, 800) - 400;
    else if (pick < 17) delta = $urandom_range(0, 10000) - 5000;
    else delta = $urandom;
    send_date(day, month, year, delta);
  endtask

  task automatic test_calendar_corners();
    send_date(1, 1, 2024, 0);
    send_date(28, 2, 2024, 1);
    send_date(28, 2, 2023, 1);
    send_date(28, 2, 1900, 1);
    send_date(28, 2, 2000, 1);
    send_date(29, 2, 2100, 0);
    send_date(31, 12, 1999, 1);
    send_date(1, 1, 2000, -1);
    send_date(31, 2, 2021, 0);
    send_date(0, 3, 2020, 0);
    send_date(30, 4, 2021, 1);
  endtask

  task automatic test_month_clamping();
    send_date(15, 0, 2020, 0);
    send_date(15, 13, 2020, 0);
    send_date(15, 14, 2020, 20);
    send_date(15, 15, 2020, -20);
  endtask

  task automatic test_saturation();
    send_date(1, 1, 1, -1);
    send_date(31, 12, 9999, 1);
    send_date(1, 1, 12000, 0);
    send_date(31, 15, 16383, -32768);
    send_date(10, 6, 0, 0);
    send_date(10, 6, 0, 32767);
    send_date(0, 0, 1, -32768);
    send_date(31, 15, 9999, 32767);
  endtask

  task automatic test_extreme_deltas();
    send_date(1, 1, 5000, 32767);
    send_date(31, 12, 5000, -32768);
  endtask

  task automatic test_random_dates(input int count);
    repeat (count) send_random_date();
  endtask

  task automatic test_back_to_back(input int count);
    bursts_on = 1'b0;
    repeat (count) send_random_date();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_calendar_corners();
    test_month_clamping();
    test_saturation();
    test_extreme_deltas();
    test_random_dates(440);
    test_back_to_back(75);
    s_tvalid <= 1'b0;
    bursts_on = 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d dates, checked %0d results, %0d of them saturated.",
             dates_sent, results_checked, saturated_seen);
    $display("Directed leap, clamp and range cases ran before the random dates.");
    if (mismatches == 0) begin
      $display("** calendar_date_add_days_top: PASSED **");
    end else begin
      $display("** calendar_date_add_days_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Timed out with %0d results still pending.", pending_dates.size());
    $display("** calendar_date_add_days_top: FAILED **");
    $finish;
  end

endmodule
